/* rtl/fkr_pkg.sv */
// Shared constants and types for the keyed-removal FIFO.
package fkr_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 16;
	localparam int FUNC_W          = 2;

	localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_SEARCH,
		ST_SHIFT
	} state_t;

endpackage

/* rtl/fkr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fkr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/fifo_with_keyed_removal.sv */
// Keyed-removal FIFO: circular buffer in one RAM with head pointer and occupancy count.
// Push, unused codes, and pop or remove on an empty queue finish in the execute state;
// pop otherwise adds one RAM read, and remove walks the search and close-up states,
// which move one entry per cycle through one read port.
// busy drops in the done cycle, so a new request can start then; the receiver cannot stall.
// Reset clears the control state and the count; RAM contents are left as they are.
module fifo_with_keyed_removal #(
	parameter int QUEUE_DEPTH = fkr_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = fkr_pkg::ID_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [fkr_pkg::FUNC_W-1:0]       func,
	input  logic [ID_BITS-1:0]               pid,
	output logic                             done,
	output logic                             found,
	output logic [ID_BITS-1:0]               out_pid,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
	output logic                             overflow
);
	import fkr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   occ_q, occ_d;
	logic [PTR_W-1:0]   idx_q, idx_d;
	logic [FUNC_W-1:0]  func_q;
	logic [ID_BITS-1:0] key_q;
	logic [ID_BITS-1:0] taken_q, taken_d;

	logic               done_q, done_d;
	logic               found_q, found_d;
	logic [ID_BITS-1:0] pid_q, pid_d;
	logic               ovf_q, ovf_d;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr, ram_raddr;
	logic [ID_BITS-1:0] ram_wdata, ram_rdata;

	logic [CNT_W:0] idx1, idx2, occ_w;

	function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
		input logic [PTR_W-1:0] lidx);
		logic [PTR_W:0] s;
		s = {1'b0, head} + {1'b0, lidx};
		if (s >= (PTR_W+1)'(QUEUE_DEPTH)) begin
			s = s - (PTR_W+1)'(QUEUE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	fkr_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign idx1  = (CNT_W+1)'(idx_q) + (CNT_W+1)'(1);
	assign idx2  = (CNT_W+1)'(idx_q) + (CNT_W+1)'(2);
	assign occ_w = {1'b0, occ_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			occ_q   <= occ_d;
			idx_q   <= idx_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			func_q <= func;
			key_q  <= pid;
		end
		taken_q <= taken_d;
		if (done_d) begin
			found_q <= found_d;
			pid_q   <= pid_d;
			ovf_q   <= ovf_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		occ_d     = occ_q;
		idx_d     = idx_q;
		taken_d   = taken_q;
		done_d    = 1'b0;
		found_d   = 1'b0;
		pid_d     = '0;
		ovf_d     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, occ_q[PTR_W-1:0]);
		ram_wdata = key_q;
		ram_raddr = head_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (func_q)
					FUNC_PUSH: begin
						done_d = 1'b1;
						if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
							ovf_d = 1'b1;
						end else begin
							ram_we = 1'b1;
							occ_d  = occ_q + CNT_W'(1);
						end
					end
					FUNC_POP: begin
						if (occ_q == '0) begin
							done_d = 1'b1;
						end else begin
							state_d = ST_POP;
						end
					end
					FUNC_REMOVE: begin
						idx_d = '0;
						if (occ_q == '0) begin
							done_d = 1'b1;
						end else begin
							state_d = ST_SEARCH;
						end
					end
					default: begin
						done_d = 1'b1;
					end
				endcase
			end
			ST_POP: begin
				done_d  = 1'b1;
				found_d = 1'b1;
				pid_d   = ram_rdata;
				head_d  = phys(head_q, PTR_W'(1));
				occ_d   = occ_q - CNT_W'(1);
			end
			ST_SEARCH: begin
				ram_raddr = phys(head_q, idx1[PTR_W-1:0]);
				if (ram_rdata == key_q) begin
					taken_d = ram_rdata;
					if (idx1 < occ_w) begin
						state_d = ST_SHIFT;
					end else begin
						done_d  = 1'b1;
						found_d = 1'b1;
						pid_d   = ram_rdata;
						occ_d   = occ_q - CNT_W'(1);
					end
				end else if (idx1 < occ_w) begin
					idx_d = idx1[PTR_W-1:0];
				end else begin
					done_d = 1'b1;
				end
			end
			ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, idx_q);
				ram_wdata = ram_rdata;
				ram_raddr = phys(head_q, idx2[PTR_W-1:0]);
				if (idx2 < occ_w) begin
					idx_d = idx1[PTR_W-1:0];
				end else begin
					done_d  = 1'b1;
					found_d = 1'b1;
					pid_d   = taken_q;
					occ_d   = occ_q - CNT_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (done_d) begin
			state_d = ST_IDLE;
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign found    = found_q;
	assign out_pid  = pid_q;
	assign count    = occ_q;
	assign overflow = ovf_q;

endmodule
